>>> design/gcb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcb_pkg
// Shared types and constants of the gradient color blend.
// ----------------------------------------------------------------------------
package gcb_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int LVL_W          = FRAC_BITS + 2;
    localparam int RISE_W         = FRAC_BITS + 1;
    localparam int HW_W           = 13;
    localparam int MAX_HALF_WIDTH = 4096;
    localparam int RGB_W          = 24;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 24;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [LVL_W-1:0]  ONE_LVL   = LVL_W'(1) << FRAC_BITS;
    localparam logic [HW_W-1:0]   HW_MAX    = HW_W'(MAX_HALF_WIDTH);

    localparam logic [CFG_IDX_W-1:0] REG_BLEND_RGB      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_START     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTENSITY_STEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_LIMIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_ENABLES   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IGNORE_RGB     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_RGB       = 3'd6;

    typedef struct packed {
        logic [7:0] blue_in;
        logic [7:0] green_in;
        logic [7:0] red_in;
        logic       first_of_frame;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] blue_out;
        logic [7:0] green_out;
        logic [7:0] red_out;
        logic       was_blended;
    } pixel_out_t;

    typedef struct packed {
        logic [RGB_W-1:0] blend_rgb;
        logic [LVL_W-1:0] fall_start;
        logic [LVL_W-1:0] intensity_step;
        logic [HW_W-1:0]  pair_limit;
        logic [1:0]       mask_enables;
        logic [RGB_W-1:0] ignore_rgb;
        logic [RGB_W-1:0] zero_rgb;
    } cfg_t;

    typedef struct packed {
        logic [7:0]       blue;
        logic [7:0]       green;
        logic [7:0]       red;
        logic [LVL_W-1:0] level;
        logic             blend;
    } job_t;

endpackage

>>> design/gcb_config.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcb_config
// Configuration register file of the gradient color blend.
// ----------------------------------------------------------------------------
module gcb_config
    import gcb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_BLEND_RGB:      cfg_next.blend_rgb      = cfg_data[RGB_W-1:0];
                REG_FALL_START:     cfg_next.fall_start     = cfg_data[LVL_W-1:0];
                REG_INTENSITY_STEP: cfg_next.intensity_step = cfg_data[LVL_W-1:0];
                REG_PAIR_LIMIT:     cfg_next.pair_limit     = cfg_data[HW_W-1:0];
                REG_MASK_ENABLES:   cfg_next.mask_enables   = cfg_data[1:0];
                REG_IGNORE_RGB:     cfg_next.ignore_rgb     = cfg_data[RGB_W-1:0];
                REG_ZERO_RGB:       cfg_next.zero_rgb       = cfg_data[RGB_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blend_rgb      <= '0;
            cfg_reg.fall_start     <= ONE_LVL;
            cfg_reg.intensity_step <= '0;
            cfg_reg.pair_limit     <= HW_W'(1);
            cfg_reg.mask_enables   <= '0;
            cfg_reg.ignore_rgb     <= '0;
            cfg_reg.zero_rgb       <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> design/gcb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcb_front
// Pixel intake: column and ramp tracking, protected color check.
// ----------------------------------------------------------------------------
module gcb_front
    import gcb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      pix_valid,
    output logic      pix_ready,
    input  pixel_in_t pix,
    output logic      push_valid,
    input  logic      push_ready,
    output job_t      push_data
);

    logic [LVL_W-1:0]  fall_reg, fall_next;
    logic [RISE_W-1:0] rise_reg, rise_next;
    logic [HW_W-1:0]   cnt_reg, cnt_next;
    logic              odd_reg, odd_next;

    logic [LVL_W-1:0]  fall_eff;
    logic [RISE_W-1:0] rise_eff;
    logic [HW_W-1:0]   cnt_eff;
    logic              odd_eff;
    logic [LVL_W-1:0]  fall_dec;
    logic [LVL_W:0]    rise_sum;
    logic [RISE_W-1:0] rise_inc;
    logic [HW_W-1:0]   cnt_inc;
    logic [HW_W-1:0]   hw_eff;
    logic [RGB_W-1:0]  px;
    logic              prot;
    logic              take;

    assign pix_ready  = push_ready;
    assign push_valid = pix_valid;
    assign take       = pix_valid && push_ready;

    assign px = {pix.red_in, pix.green_in, pix.blue_in};

    assign fall_eff = pix.first_of_frame ? cfg.fall_start : fall_reg;
    assign rise_eff = pix.first_of_frame ? '0 : rise_reg;
    assign cnt_eff  = pix.first_of_frame ? '0 : cnt_reg;
    assign odd_eff  = pix.first_of_frame ? 1'b0 : odd_reg;

    assign prot = (cfg.mask_enables[0] && (px == cfg.ignore_rgb)) ||
                  (cfg.mask_enables[1] && (px == cfg.zero_rgb));

    assign push_data.blue  = pix.blue_in;
    assign push_data.green = pix.green_in;
    assign push_data.red   = pix.red_in;
    assign push_data.level = odd_eff ? {1'b0, rise_eff} : fall_eff;
    assign push_data.blend = !prot;

    assign fall_dec = (fall_eff > cfg.intensity_step) ? (fall_eff - cfg.intensity_step) : '0;
    assign rise_sum = {2'b00, rise_eff} + {1'b0, cfg.intensity_step};
    assign rise_inc = (rise_sum > {1'b0, ONE_LVL}) ? ONE_LVL[RISE_W-1:0]
                                                   : rise_sum[RISE_W-1:0];
    assign cnt_inc  = cnt_eff + HW_W'(1);

    always_comb
    begin
        if (cfg.pair_limit == '0)
            hw_eff = HW_W'(1);
        else if (cfg.pair_limit > HW_MAX)
            hw_eff = HW_MAX;
        else
            hw_eff = cfg.pair_limit;
    end

    always_comb
    begin
        fall_next = fall_reg;
        rise_next = rise_reg;
        cnt_next  = cnt_reg;
        odd_next  = odd_reg;
        if (take)
        begin
            if (!odd_eff)
            begin
                fall_next = fall_eff;
                rise_next = rise_eff;
                cnt_next  = cnt_eff;
                odd_next  = 1'b1;
            end
            else if (cnt_inc >= hw_eff)
            begin
                fall_next = cfg.fall_start;
                rise_next = '0;
                cnt_next  = '0;
                odd_next  = 1'b0;
            end
            else
            begin
                fall_next = fall_dec;
                rise_next = rise_inc;
                cnt_next  = cnt_inc;
                odd_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fall_reg <= ONE_LVL;
            rise_reg <= '0;
            cnt_reg  <= '0;
            odd_reg  <= 1'b0;
        end
        else
        begin
            fall_reg <= fall_next;
            rise_reg <= rise_next;
            cnt_reg  <= cnt_next;
            odd_reg  <= odd_next;
        end
    end

endmodule

>>> design/gcb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcb_queue
// Short job queue between the intake and the blend stage.
// ----------------------------------------------------------------------------
module gcb_queue
    import gcb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    job_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (!do_push && do_pop)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> design/gcb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcb_back
// Blend stage: per-channel scale, add or subtract and saturate into the result register.
// ----------------------------------------------------------------------------
module gcb_back
    import gcb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [RGB_W-1:0] blend_rgb,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  job_t             pop_data,
    output logic             res_valid,
    input  logic             res_ready,
    output pixel_out_t       res
);

    localparam int PROD_W = 8 + LVL_W;
    localparam int MAG_W  = PROD_W - FRAC_BITS;
    localparam int SUM_W  = MAG_W + 2;

    function automatic logic [7:0] mix_channel(input logic [7:0] c, input logic [7:0] target,
                                               input logic [LVL_W-1:0] lvl);
        logic [7:0]        diff;
        logic [PROD_W-1:0] prod;
        logic [MAG_W-1:0]  mag;
        logic signed [SUM_W-1:0] sum;
        logic [7:0]        result;
        diff = (target >= c) ? (target - c) : (c - target);
        prod = PROD_W'(diff) * PROD_W'(lvl);
        mag  = prod[PROD_W-1:FRAC_BITS];
        if (target >= c)
            sum = $signed({{(SUM_W-8){1'b0}}, c}) + $signed({2'b00, mag});
        else
            sum = $signed({{(SUM_W-8){1'b0}}, c}) - $signed({2'b00, mag});
        if (sum < 0)
            result = 8'd0;
        else if (sum > $signed(SUM_W'(255)))
            result = 8'd255;
        else
            result = sum[7:0];
        return result;
    endfunction

    logic       valid_reg, valid_next;
    pixel_out_t res_reg, res_next;
    logic       load;

    assign pop_ready = !valid_reg || res_ready;
    assign load      = pop_valid && pop_ready;
    assign res_valid = valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        res_next = res_reg;
        if (pop_data.blend)
        begin
            res_next.blue_out  = mix_channel(pop_data.blue,  blend_rgb[7:0],   pop_data.level);
            res_next.green_out = mix_channel(pop_data.green, blend_rgb[15:8],  pop_data.level);
            res_next.red_out   = mix_channel(pop_data.red,   blend_rgb[23:16], pop_data.level);
        end
        else
        begin
            res_next.blue_out  = pop_data.blue;
            res_next.green_out = pop_data.green;
            res_next.red_out   = pop_data.red;
        end
        res_next.was_blended = pop_data.blend;
    end

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (res_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

endmodule

>>> design/gradient_color_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_color_blend
// Blends a configured color into a BGR pixel stream with paired column ramps.
// ----------------------------------------------------------------------------
// One pixel beat is taken every clock and one result beat leaves every clock
// when the output side keeps taking them. A result beat is offered once its
// job has passed the queue and the result register: the intake writes the
// job into a two-entry queue at the accepting edge, and the blend stage,
// holding three 8x18 multipliers, then loads the result register from the
// queue. The queue and the result register let input and output stall apart;
// with the output held off, three pixels are taken before the input stalls.
// Configuration writes complete in the cycle they are presented.
// ----------------------------------------------------------------------------
module gradient_color_blend
    import gcb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  pix_valid,
    output logic                  pix_ready,
    input  pixel_in_t             pix,
    output logic                  res_valid,
    input  logic                  res_ready,
    output pixel_out_t            res
);

    cfg_t cfg;
    logic push_valid;
    logic push_ready;
    job_t push_data;
    logic pop_valid;
    logic pop_ready;
    job_t pop_data;

    gcb_config u_config (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gcb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready),
        .pix        (pix),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    gcb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    gcb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .blend_rgb (cfg.blend_rgb),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the gradient color blend.
// Pixels go in over a valid/ready channel and every accepted beat is run
// through a cycle-free model of the two column ramps and the per-channel
// blend; result beats are compared field by field against the oldest
// prediction. Directed checks cover field extremes, protected colors,
// saturation, half width limits and a start intensity change inside a row.
// Random frames follow under several register settings and idle patterns,
// then a long row with an oversized half width and a long output stall.
// ----------------------------------------------------------------------------
module tb;
    import gcb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_REPORTS = 10;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  pix_valid = 1'b0;
    logic                  pix_ready;
    pixel_in_t             pix       = '0;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    pixel_out_t            res;

    cfg_t             blend_cfg;
    logic [LVL_W-1:0] fall_lvl;
    logic [RISE_W-1:0] rise_lvl;
    logic [HW_W-1:0]  pairs_done;
    logic             odd_col;
    pixel_out_t       pending_pixels[$];

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int long_stall_len = 0;
    int stall_left     = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    gradient_color_blend u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL gradient_color_blend");
        $finish;
    end

    function automatic logic [7:0] mix_toward(input logic [7:0] c, input logic [7:0] target,
                                              input logic [LVL_W-1:0] lvl);
        longint span;
        longint total;
        if (target >= c)
        begin
            span  = longint'(target) - longint'(c);
            total = longint'(c) + ((span * longint'(lvl)) >> FRAC_BITS);
        end
        else
        begin
            span  = longint'(c) - longint'(target);
            total = longint'(c) - ((span * longint'(lvl)) >> FRAC_BITS);
        end
        if (total < 0)
            return 8'd0;
        if (total > 255)
            return 8'd255;
        return 8'(total);
    endfunction

    task automatic restart_ramps();
        fall_lvl   = blend_cfg.fall_start;
        rise_lvl   = '0;
        pairs_done = '0;
        odd_col    = 1'b0;
    endtask

    task automatic step_blend_model(input pixel_in_t p);
        logic [RGB_W-1:0] rgb;
        logic [LVL_W-1:0] lvl;
        logic             guarded;
        pixel_out_t       o;
        int               rise_next;
        int               row_pairs;
        if (p.first_of_frame)
            restart_ramps();
        rgb = {p.red_in, p.green_in, p.blue_in};
        lvl = odd_col ? LVL_W'(rise_lvl) : fall_lvl;
        guarded = (blend_cfg.mask_enables[0] && rgb == blend_cfg.ignore_rgb) ||
                  (blend_cfg.mask_enables[1] && rgb == blend_cfg.zero_rgb);
        if (guarded)
        begin
            o.blue_out    = p.blue_in;
            o.green_out   = p.green_in;
            o.red_out     = p.red_in;
            o.was_blended = 1'b0;
        end
        else
        begin
            o.blue_out    = mix_toward(p.blue_in, blend_cfg.blend_rgb[7:0], lvl);
            o.green_out   = mix_toward(p.green_in, blend_cfg.blend_rgb[15:8], lvl);
            o.red_out     = mix_toward(p.red_in, blend_cfg.blend_rgb[23:16], lvl);
            o.was_blended = 1'b1;
        end
        pending_pixels.push_back(o);

        if (!odd_col)
            odd_col = 1'b1;
        else
        begin
            odd_col  = 1'b0;
            fall_lvl = (fall_lvl > blend_cfg.intensity_step) ?
                       fall_lvl - blend_cfg.intensity_step : '0;
            rise_next = int'(rise_lvl) + int'(blend_cfg.intensity_step);
            rise_lvl  = (rise_next > int'(ONE_LVL)) ? RISE_W'(ONE_LVL) : RISE_W'(rise_next);
            if (blend_cfg.pair_limit == '0)
                row_pairs = 1;
            else if (int'(blend_cfg.pair_limit) > MAX_HALF_WIDTH)
                row_pairs = MAX_HALF_WIDTH;
            else
                row_pairs = int'(blend_cfg.pair_limit);
            pairs_done = pairs_done + 1'b1;
            if (int'(pairs_done) >= row_pairs)
                restart_ramps();
        end
    endtask

    always @(posedge clk)
    begin
        pixel_out_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_BLEND_RGB:      blend_cfg.blend_rgb      = cfg_data[RGB_W-1:0];
                    REG_FALL_START:     blend_cfg.fall_start     = cfg_data[LVL_W-1:0];
                    REG_INTENSITY_STEP: blend_cfg.intensity_step = cfg_data[LVL_W-1:0];
                    REG_PAIR_LIMIT:     blend_cfg.pair_limit     = cfg_data[HW_W-1:0];
                    REG_MASK_ENABLES:   blend_cfg.mask_enables   = cfg_data[1:0];
                    REG_IGNORE_RGB:     blend_cfg.ignore_rgb     = cfg_data[RGB_W-1:0];
                    REG_ZERO_RGB:       blend_cfg.zero_rgb       = cfg_data[RGB_W-1:0];
                    default:            ;
                endcase
            end
            if (pix_valid && pix_ready)
                step_blend_model(pix);
            if (res_valid && res_ready)
            begin
                if (pending_pixels.size() == 0)
                begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("unexpected result beat: b=%02h g=%02h r=%02h blended=%0b",
                                 res.blue_out, res.green_out, res.red_out, res.was_blended);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    if (res.blue_out !== want.blue_out || res.green_out !== want.green_out ||
                        res.red_out !== want.red_out || res.was_blended !== want.was_blended)
                    begin
                        if (mismatch_count < MAX_REPORTS)
                            $display({"result mismatch: expected b=%02h g=%02h r=%02h ",
                                      "blended=%0b, got b=%02h g=%02h r=%02h blended=%0b"},
                                     want.blue_out, want.green_out, want.red_out,
                                     want.was_blended, res.blue_out, res.green_out,
                                     res.red_out, res.was_blended);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (long_stall_len != 0)
        begin
            stall_left     = long_stall_len;
            long_stall_len = 0;
        end
        if (stall_left != 0)
        begin
            stall_left--;
            res_ready <= 1'b0;
        end
        else
            res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_pixel(input logic [RGB_W-1:0] rgb, input logic frame_start);
        pixel_in_t p;
        p.red_in         = rgb[23:16];
        p.green_in       = rgb[15:8];
        p.blue_in        = rgb[7:0];
        p.first_of_frame = frame_start;
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix       <= p;
        @(posedge clk);
        while (!pix_ready)
            @(posedge clk);
    endtask

    task automatic drain_pipeline();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pad_garbage(input int unsigned value,
                                                          input int width);
        return CFG_DATA_W'(($urandom() << width) | value);
    endfunction

    function automatic logic [RGB_W-1:0] pick_color();
        case ($urandom_range(9))
            0, 1:    return blend_cfg.ignore_rgb;
            2:       return blend_cfg.zero_rgb;
            3:       return {$urandom_range(1) ? 8'hFF : 8'h00, $urandom_range(1) ? 8'hFF : 8'h00,
                             $urandom_range(1) ? 8'hFF : 8'h00};
            default: return RGB_W'($urandom());
        endcase
    endfunction

    task automatic randomize_config();
        logic [LVL_W-1:0] start_val;
        int unsigned      step_val;
        int               hw_val;
        int               hw_eff;
        case ($urandom_range(4))
            0:       start_val = '0;
            1:       start_val = ONE_LVL;
            2:       start_val = 18'h20000;
            3:       start_val = '1;
            default: start_val = LVL_W'($urandom());
        endcase
        case ($urandom_range(9))
            0:       hw_val = 0;
            1:       hw_val = MAX_HALF_WIDTH;
            2:       hw_val = 13'h1FFF;
            3:       hw_val = $urandom_range(1, 13'h1FFF);
            default: hw_val = $urandom_range(1, 6);
        endcase
        hw_eff = (hw_val == 0) ? 1 : (hw_val > MAX_HALF_WIDTH) ? MAX_HALF_WIDTH : hw_val;
        case ($urandom_range(5))
            0:       step_val = 0;
            1:       step_val = 18'h3FFFF;
            2:       step_val = $urandom_range(0, 18'h3FFFF);
            default: step_val = int'(start_val) / hw_eff;
        endcase
        write_reg(REG_BLEND_RGB, CFG_DATA_W'($urandom()));
        write_reg(REG_FALL_START, pad_garbage(start_val, LVL_W));
        write_reg(REG_INTENSITY_STEP, pad_garbage(step_val, LVL_W));
        write_reg(REG_PAIR_LIMIT, pad_garbage(hw_val, HW_W));
        write_reg(REG_MASK_ENABLES, pad_garbage($urandom_range(3), 2));
        write_reg(REG_IGNORE_RGB, CFG_DATA_W'($urandom()));
        write_reg(REG_ZERO_RGB, $urandom_range(1) ? '0 : CFG_DATA_W'($urandom()));
        if ($urandom_range(3) == 0)
            write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
    endtask

    task automatic test_reset_values();
        send_pixel(24'hFFFFFF, 1'b0);
        send_pixel(24'h123456, 1'b0);
    endtask

    task automatic test_field_extremes();
        drain_pipeline();
        write_reg(REG_BLEND_RGB, 24'h00FF80);
        write_reg(REG_FALL_START, 24'hFE0000);
        write_reg(REG_INTENSITY_STEP, 24'hFC4000);
        write_reg(REG_PAIR_LIMIT, 24'hFFE003);
        write_reg(REG_MASK_ENABLES, 24'hFFFFFC);
        write_reg(REG_IGNORE_RGB, 24'hFFFFFF);
        write_reg(REG_ZERO_RGB, 24'h000000);
        write_reg(REG_UNUSED, 24'hFFFFFF);
        send_pixel(24'h000000, 1'b1);
        send_pixel(24'hFFFFFF, 1'b0);
        send_pixel(24'h00FF80, 1'b0);
        send_pixel(24'hFF0000, 1'b0);
        send_pixel(24'h0000FF, 1'b0);
        send_pixel(24'h7F7F7F, 1'b0);
        send_pixel(24'hFFFFFF, 1'b0);
        send_pixel(24'h000000, 1'b0);
    endtask

    task automatic test_protected_colors();
        drain_pipeline();
        write_reg(REG_MASK_ENABLES, 24'h000003);
        write_reg(REG_IGNORE_RGB, 24'h123456);
        write_reg(REG_ZERO_RGB, 24'h000000);
        write_reg(REG_BLEND_RGB, 24'hFFFFFF);
        write_reg(REG_FALL_START, 24'h010000);
        write_reg(REG_INTENSITY_STEP, 24'hFFFFFF);
        write_reg(REG_PAIR_LIMIT, 24'h000000);
        send_pixel(24'h123456, 1'b1);
        send_pixel(24'h000000, 1'b0);
        send_pixel(24'h123457, 1'b0);
        send_pixel(24'h000001, 1'b0);
        drain_pipeline();
        write_reg(REG_MASK_ENABLES, 24'h000001);
        send_pixel(24'h000000, 1'b0);
        send_pixel(24'h123456, 1'b0);
        drain_pipeline();
        write_reg(REG_MASK_ENABLES, 24'h000002);
        send_pixel(24'h123456, 1'b0);
        send_pixel(24'h000000, 1'b0);
    endtask

    task automatic test_start_midrow();
        drain_pipeline();
        write_reg(REG_PAIR_LIMIT, 24'h000003);
        write_reg(REG_FALL_START, 24'h010000);
        write_reg(REG_INTENSITY_STEP, 24'h002000);
        write_reg(REG_BLEND_RGB, 24'h80FF00);
        write_reg(REG_MASK_ENABLES, 24'h000000);
        send_pixel(24'h808080, 1'b1);
        send_pixel(24'h203040, 1'b0);
        drain_pipeline();
        write_reg(REG_FALL_START, 24'h008000);
        send_pixel(24'hFFFFFF, 1'b0);
        send_pixel(24'h000000, 1'b0);
        send_pixel(24'hC0C0C0, 1'b0);
        send_pixel(24'h102030, 1'b0);
        send_pixel(24'hFF00FF, 1'b0);
        send_pixel(24'h00FF00, 1'b0);
    endtask

    task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                       input int settings, input int per_setting);
        int sent;
        int run_len;
        repeat (settings)
        begin
            drain_pipeline();
            randomize_config();
            send_idle_pct = sender_pct;
            recv_idle_pct = receiver_pct;
            sent = 0;
            while (sent < per_setting)
            begin
                if ($urandom_range(9) == 0)
                begin
                    send_pixel(pick_color(), 1'($urandom_range(1)));
                    sent++;
                end
                else
                begin
                    run_len = $urandom_range(2, 48);
                    for (int k = 0; k < run_len; k++)
                        send_pixel(pick_color(), k == 0 && $urandom_range(7) != 0);
                    sent += run_len;
                end
            end
        end
    endtask

    task automatic test_long_row();
        drain_pipeline();
        write_reg(REG_PAIR_LIMIT, 24'hFFFFFF);
        write_reg(REG_INTENSITY_STEP, 24'h000001);
        write_reg(REG_FALL_START, 24'h010000);
        write_reg(REG_BLEND_RGB, CFG_DATA_W'($urandom()));
        write_reg(REG_MASK_ENABLES, 24'h000000);
        for (int k = 0; k < 128; k++)
            send_pixel(RGB_W'($urandom()), k == 0);
    endtask

    task automatic test_backpressure();
        drain_pipeline();
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        long_stall_len = 300;
        for (int k = 0; k < 40; k++)
            send_pixel(pick_color(), k == 0);
    endtask

    initial
    begin
        blend_cfg            = '0;
        blend_cfg.fall_start = ONE_LVL;
        blend_cfg.pair_limit = HW_W'(1);
        restart_ramps();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 32;
        recv_idle_pct = 77;
        test_reset_values();
        test_field_extremes();
        test_protected_colors();
        test_start_midrow();
        test_random_traffic(32, 77, 2, 220);
        test_random_traffic(77, 32, 2, 220);
        test_random_traffic(0, 0, 2, 220);
        test_long_row();
        test_backpressure();
        drain_pipeline();
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS gradient_color_blend");
        else
            $display("FAIL gradient_color_blend");
        $finish;
    end

endmodule

>>> gradient_color_blend.f
design/gcb_pkg.sv
design/gcb_config.sv
design/gcb_front.sv
design/gcb_queue.sv
design/gcb_back.sv
design/gradient_color_blend.sv
bench/tb.sv
